// ===== sv/lbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink/fade effect package
// Shared colour type, effect mode codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfe_pkg;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   typedef enum logic [1:0] {
      MODE_STEADY = 2'd0,
      MODE_BLINK  = 2'd1,
      MODE_FADE   = 2'd2
   } mode_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EFFECT_MODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_RED   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_GREEN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_BLUE  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_DELAY = 3'd4;

   localparam logic [31:0] FRAME_DELAY_RESET = 32'd500000;

endpackage

`default_nettype wire

// ===== sv/lbfe_color_scale.sv =====
// ----------------------------------------------------------------------------
// LED colour scaler
// Scales each channel of a colour by level/255, rounding down.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfe_color_scale (
   input  wire lbfe_pkg::rgb_type base,
   input  wire logic [7:0]        level,
   output      lbfe_pkg::rgb_type scaled
);

   logic [15:0] prod_r;
   logic [15:0] prod_g;
   logic [15:0] prod_b;
   logic [16:0] sum_r;
   logic [16:0] sum_g;
   logic [16:0] sum_b;

   // x/255 == (x + 1 + (x >> 8)) >> 8 for every x up to 65534, which covers every 8x8-bit product
   always_comb begin
      prod_r = 16'(base.red)   * 16'(level);
      prod_g = 16'(base.green) * 16'(level);
      prod_b = 16'(base.blue)  * 16'(level);
      sum_r  = 17'(prod_r) + 17'd1 + 17'(prod_r[15:8]);
      sum_g  = 17'(prod_g) + 17'd1 + 17'(prod_g[15:8]);
      sum_b  = 17'(prod_b) + 17'd1 + 17'(prod_b[15:8]);
      scaled.red   = sum_r[15:8];
      scaled.green = sum_g[15:8];
      scaled.blue  = sum_b[15:8];
   end

endmodule

`default_nettype wire

// ===== sv/led_blink_fade_effect_top.sv =====
// ----------------------------------------------------------------------------
// LED blink/fade effect generator
// Tick-driven RGB effect: steady colour, blink on/off, or fade up and down.
// ----------------------------------------------------------------------------
// Each request transfer carries one time tick (advance) and an optional
// restart, and yields exactly one response transfer with the colour now on
// the LED and a strobe that marks a freshly written colour. The block takes
// one transfer per clock; each passes through the request register and then
// the response register, with the counter compare and the colour scaler
// between them. A stalled response holds throughput to the rate at which
// rsp_tready is granted. The user must write registers through the csr_ port
// only while no transfer is in flight; the block itself does not enforce it.
`default_nettype none

module led_blink_fade_effect_top #(
   parameter int unsigned DELAY_BITS = 32
) (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   // request: [0] advance, [1] restart
   input  wire  logic                                  req_tvalid,
   output       logic                                  req_tready,
   input  wire  logic [7:0]                            req_tdata,
   // response: [7:0] led_red, [15:8] led_green, [23:16] led_blue
   output       logic                                  rsp_tvalid,
   input  wire  logic                                  rsp_tready,
   output       logic [23:0]                           rsp_tdata,
   // response: [0] write_strobe
   output       logic                                  rsp_tuser,
   input  wire  logic                                  csr_we,
   input  wire  logic [lbfe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  logic [lbfe_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   // Wait comparisons run at the wider of the delay register and the counter
   localparam int unsigned WIDE = (DELAY_BITS > 32) ? DELAY_BITS : 32;
   localparam logic [64:0] LIMIT_FULL = (65'd1 << DELAY_BITS) - 65'd1;
   localparam logic [WIDE-1:0] LIMIT = LIMIT_FULL[WIDE-1:0];

   // Configuration registers
   logic [1:0]        mode_ff;
   lbfe_pkg::rgb_type base_ff;
   logic [31:0]       delay_ff;

   // Request stage
   logic s1_valid_ff, s1_valid_in;
   logic s1_adv_ff;
   logic s1_restart_ff;

   // Effect state
   logic [DELAY_BITS-1:0] wait_ff, wait_in;
   logic [8:0]            step_ff, step_in;
   logic                  running_ff, running_in;
   lbfe_pkg::rgb_type     color_ff, color_in;

   // Response stage
   logic              rsp_valid_ff, rsp_valid_in;
   lbfe_pkg::rgb_type rsp_color_ff;
   logic              rsp_strobe_ff;

   logic                  out_free;
   logic                  s1_fire;
   logic [DELAY_BITS-1:0] eff_wait;
   logic [8:0]            eff_step;
   logic                  eff_run;
   logic                  timed_mode;
   logic                  do_write;
   logic [8:0]            wr_step;
   logic [7:0]            level;
   logic [31:0]           wait_src;
   logic [WIDE-1:0]       wait_wide;
   logic [DELAY_BITS-1:0] wait_load;
   lbfe_pkg::rgb_type     write_color;
   lbfe_pkg::rgb_type     faded;

   // Response register frees when empty or being taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_strobe_ff;

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lbfe_pkg::MODE_STEADY;
         base_ff  <= '0;
         delay_ff <= lbfe_pkg::FRAME_DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lbfe_pkg::CSR_EFFECT_MODE: mode_ff        <= csr_wdata[1:0];
            lbfe_pkg::CSR_COLOR_RED:   base_ff.red    <= csr_wdata[7:0];
            lbfe_pkg::CSR_COLOR_GREEN: base_ff.green  <= csr_wdata[7:0];
            lbfe_pkg::CSR_COLOR_BLUE:  base_ff.blue   <= csr_wdata[7:0];
            lbfe_pkg::CSR_FRAME_DELAY: delay_ff       <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   lbfe_color_scale u_scale (
      .base   (base_ff),
      .level  (level),
      .scaled (faded)
   );

   always_comb begin
      // restart clears the pattern before the tick is looked at
      eff_wait   = s1_restart_ff ? '0 : wait_ff;
      eff_step   = s1_restart_ff ? '0 : step_ff;
      eff_run    = s1_restart_ff ? 1'b0 : running_ff;
      timed_mode = (mode_ff == lbfe_pkg::MODE_BLINK) || (mode_ff == lbfe_pkg::MODE_FADE);
      do_write   = s1_adv_ff &&
                   (!eff_run || (timed_mode && (eff_wait <= DELAY_BITS'(1))));
      wr_step    = eff_run ? eff_step : 9'd0;
      // level climbs 0..255 then falls 255..0 over the second half
      level      = wr_step[8] ? ~wr_step[7:0] : wr_step[7:0];

      case (mode_ff)
         lbfe_pkg::MODE_BLINK: begin
            write_color = wr_step[0] ? '0 : base_ff;
            wait_src    = delay_ff;
         end
         lbfe_pkg::MODE_FADE: begin
            write_color = faded;
            wait_src    = delay_ff >> 8;
         end
         default: begin
            write_color = base_ff;
            wait_src    = '0;
         end
      endcase

      // saturate the wait at the counter's range
      wait_wide = WIDE'(wait_src);
      wait_load = (wait_wide > LIMIT) ? LIMIT[DELAY_BITS-1:0] : wait_wide[DELAY_BITS-1:0];

      wait_in    = eff_wait;
      step_in    = eff_step;
      running_in = eff_run;
      color_in   = color_ff;
      if (do_write) begin
         wait_in    = wait_load;
         step_in    = wr_step + 9'd1;
         running_in = 1'b1;
         color_in   = write_color;
      end else if (s1_adv_ff && eff_run && timed_mode) begin
         wait_in = eff_wait - DELAY_BITS'(1);
      end

      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wait_ff      <= '0;
         step_ff      <= '0;
         running_ff   <= 1'b0;
         color_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // advance the effect only when the item moves on
         if (s1_fire) begin
            wait_ff    <= wait_in;
            step_ff    <= step_in;
            running_ff <= running_in;
            color_ff   <= color_in;
         end
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_adv_ff     <= req_tdata[0];
         s1_restart_ff <= req_tdata[1];
      end
      if (s1_fire) begin
         rsp_color_ff  <= color_in;
         rsp_strobe_ff <= do_write;
      end
   end

`ifndef SYNTHESIS
   // only a restart stops a running pattern
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_restart_ff && running_ff) |=> running_ff)
      else $error("pattern stopped without restart");

   // the step moves only on a write or a restart
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_restart_ff && !do_write) |=> $stable(step_ff))
      else $error("step changed without a write");

   // a moving item always lands in the response register
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("item lost between stages");

   // a fade level never brightens a channel beyond the base colour
   assert property (@(posedge clock) disable iff (reset)
      (do_write && (mode_ff == lbfe_pkg::MODE_FADE)) |->
      ((faded.red <= base_ff.red) && (faded.green <= base_ff.green) &&
       (faded.blue <= base_ff.blue)))
      else $error("fade scaled above base colour");

   // the colour is unchanged unless written
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !do_write) |=> $stable(color_ff))
      else $error("colour changed without a write");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_led_blink_fade_effect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink/fade effect testbench
// Drives timer ticks and restarts into the effect generator, predicts the
// colour and write strobe of every response, and checks each response in
// order against that prediction under varied register settings and idling.
// ----------------------------------------------------------------------------

module tb_led_blink_fade_effect_top;

   // Mode code 3 has no enum member; the block treats it as steady
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // One predicted response: colour packed as on rsp_tdata, plus the strobe
   typedef struct packed {
      logic              strobe;
      lbfe_pkg::rgb_type colour;
   } led_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the effect state and holds the colours still due
   // -------------------------------------------------------------------------
   class led_effect_scoreboard_type;
      logic [1:0]        mode;
      lbfe_pkg::rgb_type base;
      logic [31:0]       delay;
      logic [31:0]       wait_left;
      logic [8:0]        step;
      bit                running;
      lbfe_pkg::rgb_type shown;
      led_result_type    colour_q[$];
      int                errors;
      int                ticks;
      int                writes;

      function new();
         mode      = lbfe_pkg::MODE_STEADY;
         base      = '0;
         delay     = lbfe_pkg::FRAME_DELAY_RESET;
         wait_left = '0;
         step      = '0;
         running   = 1'b0;
         shown     = '0;
         errors    = 0;
         ticks     = 0;
         writes    = 0;
      endfunction

      function void write_reg(logic [lbfe_pkg::CSR_INDEX_WIDTH-1:0] idx,
                              logic [lbfe_pkg::CSR_DATA_WIDTH-1:0] value);
         case (idx)
            lbfe_pkg::CSR_EFFECT_MODE: mode       = value[1:0];
            lbfe_pkg::CSR_COLOR_RED:   base.red   = value[7:0];
            lbfe_pkg::CSR_COLOR_GREEN: base.green = value[7:0];
            lbfe_pkg::CSR_COLOR_BLUE:  base.blue  = value[7:0];
            lbfe_pkg::CSR_FRAME_DELAY: delay      = value[31:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] scale_channel(logic [7:0] c, logic [7:0] lvl);
         logic [15:0] prod;
         prod = c * lvl;
         return 8'(prod / 16'd255);
      endfunction

      // Write the colour of the current step and return the wait to load
      function logic [31:0] write_step();
         logic [7:0]  lvl;
         logic [31:0] next_wait;
         case (mode)
            lbfe_pkg::MODE_BLINK: begin
               shown     = step[0] ? lbfe_pkg::rgb_type'('0) : base;
               next_wait = delay;
            end
            lbfe_pkg::MODE_FADE: begin
               // ramp up over steps 0..255, back down over 256..511
               lvl         = step[8] ? ~step[7:0] : step[7:0];
               shown.red   = scale_channel(base.red, lvl);
               shown.green = scale_channel(base.green, lvl);
               shown.blue  = scale_channel(base.blue, lvl);
               next_wait   = delay >> 8;
            end
            default: begin
               shown     = base;
               next_wait = '0;
            end
         endcase
         step = step + 9'd1;
         return next_wait;
      endfunction

      function void note_tick(bit advance, bit restart_req);
         bit strobe;
         strobe = 1'b0;
         ticks++;
         if (restart_req) begin
            wait_left = '0;
            step      = '0;
            running   = 1'b0;
         end
         if (advance) begin
            if (!running) begin
               step      = '0;
               wait_left = write_step();
               running   = 1'b1;
               strobe    = 1'b1;
            end else if (mode == lbfe_pkg::MODE_BLINK || mode == lbfe_pkg::MODE_FADE) begin
               if (wait_left <= 32'd1) begin
                  wait_left = write_step();
                  strobe    = 1'b1;
               end else begin
                  wait_left = wait_left - 32'd1;
               end
            end
         end
         if (strobe) writes++;
         colour_q.push_back('{strobe: strobe, colour: shown});
      endfunction

      function void check_result(lbfe_pkg::rgb_type got, logic got_strobe);
         led_result_type want;
         if (colour_q.size() == 0) begin
            $display("%0t: unexpected response colour %h strobe %b",
                     $time, got, got_strobe);
            errors++;
            return;
         end
         want = colour_q.pop_front();
         if (got.red !== want.colour.red) begin
            $display("%0t: led_red expected %h actual %h",
                     $time, want.colour.red, got.red);
            errors++;
         end
         if (got.green !== want.colour.green) begin
            $display("%0t: led_green expected %h actual %h",
                     $time, want.colour.green, got.green);
            errors++;
         end
         if (got.blue !== want.colour.blue) begin
            $display("%0t: led_blue expected %h actual %h",
                     $time, want.colour.blue, got.blue);
            errors++;
         end
         if (got_strobe !== want.strobe) begin
            $display("%0t: write_strobe expected %b actual %b",
                     $time, want.strobe, got_strobe);
            errors++;
         end
      endfunction

      function int pending();
         return colour_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT inputs and outputs
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [0] advance, [1] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [7:0] red, [15:8] green, [23:16] blue
   logic        rsp_tuser;         // [0] write_strobe
   logic                                 csr_we    = 1'b0;
   logic [lbfe_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [lbfe_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int settings_applied   = 0;

   led_effect_scoreboard_type board = new();

   always #1 clock = ~clock;

   led_blink_fade_effect_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Receiver: stall at random at the falling edge, per the current pattern
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Check every response transfer at the rising edge it completes on
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(lbfe_pkg::rgb_type'(rsp_tdata), rsp_tuser);
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("timeout with %0d responses outstanding", board.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driving tasks; each starts and ends at a falling edge
   // -------------------------------------------------------------------------

   // Present one tick, idling first at random; note it once it transfers
   task automatic send_tick(bit advance, bit restart_req);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, restart_req, advance};
      do @(posedge clock); while (!req_tready);
      board.note_tick(advance, restart_req);
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted response, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write all five registers back to back while the block is idle
   task automatic program_regs(logic [1:0] mode_val, logic [7:0] red_val,
                               logic [7:0] green_val, logic [7:0] blue_val,
                               logic [31:0] delay_val);
      logic [lbfe_pkg::CSR_INDEX_WIDTH-1:0] idx [5];
      logic [lbfe_pkg::CSR_DATA_WIDTH-1:0]  vals [5];
      idx  = '{lbfe_pkg::CSR_EFFECT_MODE, lbfe_pkg::CSR_COLOR_RED,
               lbfe_pkg::CSR_COLOR_GREEN, lbfe_pkg::CSR_COLOR_BLUE,
               lbfe_pkg::CSR_FRAME_DELAY};
      vals = '{32'(mode_val), 32'(red_val), 32'(green_val), 32'(blue_val),
               delay_val};
      settle();
      for (int k = 0; k < 5; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= vals[k];
         @(posedge clock);
         board.write_reg(idx[k], vals[k]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic set_idling(int pattern);
      case (pattern)
         1:       begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
         2:       begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
         3:       begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Favour short waits so blink and fade actually step; keep the extremes
   function automatic logic [31:0] pick_delay();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'($urandom_range(1, 3));
         2:       return 32'($urandom_range(4, 20));
         3:       return 32'($urandom_range(256, 2047));
         4:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Short directed pass over the corners of every mode
   task automatic run_directed();
      // reset settings: steady, black, long delay
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);   // first write after reset
      send_tick(1'b1, 1'b0);   // steady: nothing more to write
      program_regs(lbfe_pkg::MODE_STEADY, 8'hFF, 8'h00, 8'h80, 32'd0);
      send_tick(1'b0, 1'b1);   // restart without a tick keeps the colour
      send_tick(1'b1, 1'b1);   // restart and tick rewrite at once
      // switch to blink while running; wait of two ticks
      program_regs(lbfe_pkg::MODE_BLINK, 8'hFF, 8'hFF, 8'hFF, 32'd2);
      repeat (4) send_tick(1'b1, 1'b0);
      // longest possible wait: the counter only counts down
      program_regs(lbfe_pkg::MODE_BLINK, 8'h01, 8'h80, 8'hFE, 32'hFFFF_FFFF);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      // unused mode code falls back to steady
      program_regs(MODE_UNUSED, 8'h55, 8'hAA, 8'h0F, 32'd1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      // fade with a wait of one tick, then with the longest fade wait
      program_regs(lbfe_pkg::MODE_FADE, 8'hFF, 8'h7F, 8'h01, 32'h0000_01FF);
      send_tick(1'b1, 1'b1);
      repeat (4) send_tick(1'b1, 1'b0);
      program_regs(lbfe_pkg::MODE_FADE, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      // black blink with no wait at all
      program_regs(lbfe_pkg::MODE_BLINK, 8'h00, 8'h00, 8'h00, 32'd0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idling(0);
      run_directed();

      // Random phases; the registers change between phases without a
      // restart, so the pattern carries on under the new settings
      for (int p = 0; p < 10; p++) begin
         if (p == 4) begin
            // fade at one write per tick, long enough to wrap the step
            program_regs(lbfe_pkg::MODE_FADE, pick_level(), pick_level(),
                         pick_level(), 32'($urandom_range(511)));
            set_idling(0);
            repeat (545) send_tick(1'b1, 1'b0);
         end else begin
            program_regs(2'($urandom_range(3)), pick_level(), pick_level(),
                         pick_level(), pick_delay());
            set_idling(p % 4);
            repeat (34)
               send_tick($urandom_range(99) < 80, $urandom_range(11) == 0);
         end
      end

      settle();
      $display("covered %0d ticks with %0d colour writes over %0d register settings,",
               board.ticks, board.writes, settings_applied);
      $display("steady, blink, fade and the unused mode under four idling patterns");
      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== led_blink_fade_effect_top.f =====
sv/lbfe_pkg.sv
sv/lbfe_color_scale.sv
sv/led_blink_fade_effect_top.sv
tb/tb_led_blink_fade_effect_top.sv
